// ===== design/lbb_pkg.sv =====
// Package for the label bounding box block: register indexes, coordinate
// widths and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned LabelW = 8;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [DimW-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DimW-1:0] RESET_HEIGHT = 13'd480;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // pixel transaction taken this cycle
    logic update;     // write the updated box of the held pixel
    logic dump_read;  // read the table entry at the readout index
    logic dump_load;  // load the output register, advance the index
    logic clear;      // drop all found bits, restart the index
  } lbb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_end;  // held pixel was the last of its frame
    logic idx_last;   // readout index is at the last label
    logic out_free;   // output register can take a record
  } lbb_status_t;

endpackage

`default_nettype wire

// ===== design/lbb_pixel_if.sv =====
// Pixel channel: valid/ready handshake carrying one label pixel.
// Uses lbb_pkg for the label width.
`timescale 1ns / 1ps
`default_nettype none

interface lbb_pixel_if
  import lbb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LabelW-1:0] pixel_label;

  modport source (output valid, output pixel_label, input ready);
  modport sink   (input valid, input pixel_label, output ready);
endinterface

`default_nettype wire

// ===== design/lbb_record_if.sv =====
// Record channel: valid/ready handshake carrying one bounding box record.
// Uses lbb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lbb_record_if
  import lbb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] label_index;
  logic              found;
  logic [CoordW-1:0] col_min;
  logic [CoordW-1:0] col_max;
  logic [CoordW-1:0] row_min;
  logic [CoordW-1:0] row_max;
  logic              last_record;

  modport source (output valid, output label_index, output found, output col_min,
                  output col_max, output row_min, output row_max,
                  output last_record, input ready);
  modport sink   (input valid, input label_index, input found, input col_min,
                  input col_max, input row_min, input row_max,
                  input last_record, output ready);
endinterface

`default_nettype wire

// ===== design/lbb_ctrl.sv =====
// Controller of the label bounding box block: sequences pixel updates and
// the frame-end readout. Depends on lbb_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lbb_ctrl
  import lbb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire lbb_status_t st_i,
  output lbb_cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DRD  = 2'd2;
  localparam logic [1:0] S_DOUT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = st_i.frame_end ? S_DRD : S_IDLE;
      end
      S_DRD: begin
        cmd_o.dump_read = 1'b1;
        state_d         = S_DOUT;
      end
      S_DOUT: begin
        if (st_i.out_free) begin
          cmd_o.dump_load = 1'b1;
          if (st_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/lbb_datapath.sv =====
// Datapath of the label bounding box block: raster counters, box table
// memory with found bits, min/max update and the output record register.
// Depends on lbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbb_datapath
  import lbb_pkg::*;
#(
  parameter int unsigned NUM_LABELS = 64,
  parameter int unsigned MAX_DIM    = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  input  wire logic [LabelW-1:0]  pixel_label_i,
  input  wire lbb_cmd_t           cmd_i,
  output lbb_status_t             st_o,
  input  wire logic               rec_ready_i,
  output logic                    rec_valid_o,
  output logic [IndexW-1:0]       rec_label_index_o,
  output logic                    rec_found_o,
  output logic [CoordW-1:0]       rec_col_min_o,
  output logic [CoordW-1:0]       rec_col_max_o,
  output logic [CoordW-1:0]       rec_row_min_o,
  output logic [CoordW-1:0]       rec_row_max_o,
  output logic                    rec_last_o
);

  localparam int unsigned AddrW  = $clog2(NUM_LABELS);
  localparam int unsigned EntryW = 4 * CoordW;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);
  localparam logic [LabelW:0] NumLab = (LabelW + 1)'(NUM_LABELS);

  // Configuration registers.
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] w_eff, h_eff;
  always_comb begin
    priority if (width_q == '0) w_eff = DimW'(1);
    else if (width_q > MaxDim)  w_eff = MaxDim;
    else                        w_eff = width_q;
    priority if (height_q == '0) h_eff = DimW'(1);
    else if (height_q > MaxDim)  h_eff = MaxDim;
    else                         h_eff = height_q;
  end

  // Raster counters.
  logic [CoordW-1:0] col_q, row_q;
  logic [DimW-1:0]   col_inc, row_inc;
  logic              col_wrap, row_wrap;

  assign col_inc  = {1'b0, col_q} + DimW'(1);
  assign row_inc  = {1'b0, row_q} + DimW'(1);
  assign col_wrap = col_inc >= w_eff;
  assign row_wrap = row_inc >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_inc[CoordW-1:0];
      end else begin
        col_q <= col_inc[CoordW-1:0];
      end
    end
  end

  // Held pixel.
  logic [LabelW-1:0] label_q;
  logic [CoordW-1:0] x_q, y_q;
  logic              frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_end_q <= 1'b0;
    end else if (cmd_i.accept) begin
      frame_end_q <= col_wrap && row_wrap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      label_q <= pixel_label_i;
      x_q     <= col_q;
      y_q     <= row_q;
    end
  end

  // Box table: coordinates in memory, found bits in flip-flops.
  logic [EntryW-1:0]     mem [NUM_LABELS];
  logic [EntryW-1:0]     rd_q;
  logic [NUM_LABELS-1:0] valid_q;
  logic [AddrW-1:0]      idx_q;
  logic [AddrW-1:0]      lab_addr, rd_addr;
  logic                  in_range, in_range_in, rd_en, hit;
  logic [CoordW-1:0]     e_cmin, e_cmax, e_rmin, e_rmax;
  logic [CoordW-1:0]     n_cmin, n_cmax, n_rmin, n_rmax;

  assign lab_addr    = label_q[AddrW-1:0];
  assign in_range    = {1'b0, label_q} < NumLab;
  assign in_range_in = {1'b0, pixel_label_i} < NumLab;
  assign rd_en       = (cmd_i.accept && in_range_in) || cmd_i.dump_read;
  assign rd_addr     = cmd_i.accept ? pixel_label_i[AddrW-1:0] : idx_q;
  assign hit         = in_range && valid_q[lab_addr];

  assign {e_cmin, e_cmax, e_rmin, e_rmax} = rd_q;

  always_comb begin
    if (!hit) begin
      n_cmin = x_q;
      n_cmax = x_q;
      n_rmin = y_q;
      n_rmax = y_q;
    end else begin
      n_cmin = (x_q < e_cmin) ? x_q : e_cmin;
      n_cmax = (x_q > e_cmax) ? x_q : e_cmax;
      n_rmin = (y_q < e_rmin) ? y_q : e_rmin;
      n_rmax = (y_q > e_rmax) ? y_q : e_rmax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && in_range) begin
      mem[lab_addr] <= {n_cmin, n_cmax, n_rmin, n_rmax};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.update && in_range) begin
        valid_q[lab_addr] <= 1'b1;
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.dump_load) begin
        idx_q <= idx_q + AddrW'(1);
      end
    end
  end

  // Output record register.
  logic idx_last, idx_found;
  assign idx_last  = idx_q == AddrW'(NUM_LABELS - 1);
  assign idx_found = valid_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_o <= 1'b0;
    end else if (cmd_i.dump_load) begin
      rec_valid_o <= 1'b1;
    end else if (rec_ready_i) begin
      rec_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dump_load) begin
      rec_label_index_o <= IndexW'(idx_q);
      rec_found_o       <= idx_found;
      rec_col_min_o     <= idx_found ? e_cmin : '0;
      rec_col_max_o     <= idx_found ? e_cmax : '0;
      rec_row_min_o     <= idx_found ? e_rmin : '0;
      rec_row_max_o     <= idx_found ? e_rmax : '0;
      rec_last_o        <= idx_last;
    end
  end

  assign st_o.frame_end = frame_end_q;
  assign st_o.idx_last  = idx_last;
  assign st_o.out_free  = !rec_valid_o || rec_ready_i;

endmodule

`default_nettype wire

// ===== design/label_bounding_box_core.sv =====
// Label bounding box core: per-label bounding rectangles over a label raster.
// Each pixel is accepted, then its box gets a read-modify-write of the box
// memory; no new pixel is taken until that write. Readout after a frame's
// last pixel: per record a memory read, then an output load that waits for a
// free output register; NUM_LABELS records, pixel input held off throughout.
// Reset: asynchronous active low; found bits, counters and control cleared at
// once, no clearing pass over the memory; registers return to 640 x 480.
`timescale 1ns / 1ps
`default_nettype none

module label_bounding_box_core
  import lbb_pkg::*;
#(
  parameter int unsigned NUM_LABELS = 64,
  parameter int unsigned MAX_DIM    = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  lbb_pixel_if.sink               pix,
  lbb_record_if.source            rec
);

  lbb_cmd_t    cmd;
  lbb_status_t st;

  // Controller: owns the pixel ready and the readout sequence.
  lbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix.valid),
    .in_ready_o (pix.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: counters, box memory, min/max update and the record register,
  // which holds a finished record while the controller moves on.
  lbb_datapath #(
    .NUM_LABELS (NUM_LABELS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pixel_label_i     (pix.pixel_label),
    .cmd_i             (cmd),
    .st_o              (st),
    .rec_ready_i       (rec.ready),
    .rec_valid_o       (rec.valid),
    .rec_label_index_o (rec.label_index),
    .rec_found_o       (rec.found),
    .rec_col_min_o     (rec.col_min),
    .rec_col_max_o     (rec.col_max),
    .rec_row_min_o     (rec.row_min),
    .rec_row_max_o     (rec.row_max),
    .rec_last_o        (rec.last_record)
  );

  // A pixel transaction is always followed by its update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid && pix.ready |=> !pix.ready)
    else $error("pixel accepted during table update");

  // While a non-final record is pending, the readout still owns the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec.valid && !rec.last_record |-> !pix.ready)
    else $error("pixel input open during readout");

  // A record of an unseen label carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec.valid && !rec.found |-> rec.col_min == '0 && rec.col_max == '0
                                && rec.row_min == '0 && rec.row_max == '0)
    else $error("unseen label with nonzero box");

endmodule

`default_nettype wire
